// ===== rtl/benjamini_hochberg_qvalue_defines.svh =====
// Assertion macros for the q-value block checker.
// Depends on nothing; included by the checker file.
`ifndef BENJAMINI_HOCHBERG_QVALUE_DEFINES_SVH
`define BENJAMINI_HOCHBERG_QVALUE_DEFINES_SVH

// Same-cycle implication under reset
`define BHQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define BHQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bhq_pkg.sv =====
// Shared constants for the q-value block: op and status codes, widths.
// No dependencies.
package bhq_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int DATA_W = 32;
    localparam int LN_W   = 32;
    localparam int ACC_W  = 40;
    localparam int IP_W   = 5;
    localparam int SUM_W  = 40;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_UNSCORED = 3'd2;
    localparam logic [2:0] ST_OK       = 3'd3;
    localparam logic [2:0] ST_NAN      = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

endpackage

// ===== rtl/benjamini_hochberg_qvalue.sv =====
// Top level of the Benjamini-Hochberg q-value block: stores, sequencer, stream ports.
// Depends on bhq_pkg and bhq_ln_unit.
//
// Loads, clears, unscored items and the unused op are answered straight from the idle
// state. A query on built tables binary-searches the descending score store through
// the one registered read port of the score memory. The first query after a load or
// clear rebuilds first: an insertion sort in the score memory, then one ln(n) and one
// backward pass that computes ln(rank) for each entry on the shared multiplier.
// Scores match by exact equality; the register neg_log_pi0 is sampled only during a
// rebuild.
module benjamini_hochberg_qvalue #(
    parameter int MAX_ENTRIES = bhq_pkg::MAX_ENTRIES_DEF,
    parameter int FRAC_BITS   = bhq_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,     // neg_log_pi0
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // neg_log_p
    input  logic [2:0]  s_tuser,       // op[1:0], unscored[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // neg_log_q
    output logic [2:0]  m_tuser        // status[2:0]
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = bhq_pkg::SUM_W;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SORT_INIT = 5'd1;
    localparam logic [4:0] S_SORT_RDV  = 5'd2;
    localparam logic [4:0] S_SORT_GETV = 5'd3;
    localparam logic [4:0] S_SORT_RDJ  = 5'd4;
    localparam logic [4:0] S_SORT_CMP  = 5'd5;
    localparam logic [4:0] S_SORT_PUT  = 5'd6;
    localparam logic [4:0] S_LNN       = 5'd7;
    localparam logic [4:0] S_LNN_W     = 5'd8;
    localparam logic [4:0] S_BK_LN     = 5'd9;
    localparam logic [4:0] S_BK_W      = 5'd10;
    localparam logic [4:0] S_BK_WR     = 5'd11;
    localparam logic [4:0] S_SR_INIT   = 5'd12;
    localparam logic [4:0] S_SR_CHK    = 5'd13;
    localparam logic [4:0] S_SR_CMP    = 5'd14;
    localparam logic [4:0] S_SR_END    = 5'd15;
    localparam logic [4:0] S_SR_Q      = 5'd16;

    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sh8000_0000);

    logic [4:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ready_reg, ready_next;
    logic [31:0]         pi0_reg;
    logic [31:0]         key_reg, key_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [31:0]         v_reg, v_next;
    logic [bhq_pkg::LN_W-1:0] lnn_reg, lnn_next;
    logic signed [31:0]  best_reg, best_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0]       lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]       mid_reg, mid_next;
    logic                eq_reg, eq_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_data_reg, out_data_next;
    logic [2:0]          out_status_reg, out_status_next;

    logic [31:0]         score_mem [MAX_ENTRIES];
    logic [31:0]         q_mem [MAX_ENTRIES];
    logic [31:0]         score_rdata, q_rdata;
    logic [AW-1:0]       score_raddr, score_waddr;
    logic [31:0]         score_wdata;
    logic                score_we;
    logic [AW-1:0]       q_waddr;
    logic [31:0]         q_wdata;
    logic                q_we;

    logic                ln_start, ln_done;
    logic [CW-1:0]       ln_k;
    logic [bhq_pkg::LN_W-1:0] ln_result;

    logic                in_req;
    logic [1:0]          op;
    logic                unscored;
    logic [CW:0]         mid_sum;
    logic signed [31:0]  sat_q, new_q;

    assign op       = s_tuser[1:0];
    assign unscored = s_tuser[2];
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_req   = s_tvalid && s_tready;
    assign mid_sum  = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;

    bhq_ln_unit #(
        .KW        (CW),
        .FRAC_BITS (FRAC_BITS)
    ) u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .k      (ln_k),
        .done   (ln_done),
        .result (ln_result)
    );

    // Saturate the fdr sum and fold in the running maximum
    always_comb
    begin
        if (sum_reg > SAT_MAX)
            sat_q = 32'sh7FFF_FFFF;
        else if (sum_reg < SAT_MIN)
            sat_q = 32'sh8000_0000;
        else
            sat_q = sum_reg[31:0];
        new_q = (sat_q > best_reg) ? sat_q : best_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ready_next      = ready_reg;
        key_next        = key_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        v_next          = v_reg;
        lnn_next        = lnn_reg;
        best_next       = best_reg;
        sum_next        = sum_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        eq_next         = eq_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        score_raddr     = '0;
        score_waddr     = '0;
        score_wdata     = '0;
        score_we        = 1'b0;
        q_waddr         = '0;
        q_wdata         = '0;
        q_we            = 1'b0;
        ln_start        = 1'b0;
        ln_k            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    out_data_next   = '0;
                    out_status_next = bhq_pkg::ST_ACCEPTED;
                    out_valid_next  = 1'b1;
                    if (op == bhq_pkg::OP_LOAD)
                    begin
                        if (unscored)
                            out_status_next = bhq_pkg::ST_UNSCORED;
                        else if (cnt_reg >= CW'(MAX_ENTRIES))
                            out_status_next = bhq_pkg::ST_FULL;
                        else
                        begin
                            score_we    = 1'b1;
                            score_waddr = cnt_reg[AW-1:0];
                            score_wdata = s_tdata;
                            cnt_next    = cnt_reg + CW'(1);
                            ready_next  = 1'b0;
                        end
                    end
                    else if (op == bhq_pkg::OP_QUERY)
                    begin
                        if (unscored)
                            out_status_next = bhq_pkg::ST_NAN;
                        else
                        begin
                            out_valid_next = 1'b0;
                            key_next       = s_tdata;
                            state_next     = ready_reg ? S_SR_INIT : S_SORT_INIT;
                        end
                    end
                    else if (op == bhq_pkg::OP_CLEAR)
                    begin
                        cnt_next   = '0;
                        ready_next = 1'b0;
                    end
                end
            end
            S_SORT_INIT:
            begin
                i_next     = CW'(1);
                state_next = (cnt_reg <= CW'(1)) ? S_LNN : S_SORT_RDV;
            end
            S_SORT_RDV:
            begin
                score_raddr = i_reg[AW-1:0];
                state_next  = S_SORT_GETV;
            end
            S_SORT_GETV:
            begin
                v_next     = score_rdata;
                j_next     = i_reg;
                state_next = S_SORT_RDJ;
            end
            S_SORT_RDJ:
            begin
                score_raddr = AW'(j_reg - CW'(1));
                state_next  = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                // Shift a smaller neighbor up, or stop here
                if (score_rdata < v_reg)
                begin
                    score_we    = 1'b1;
                    score_waddr = j_reg[AW-1:0];
                    score_wdata = score_rdata;
                    j_next      = j_reg - CW'(1);
                    state_next  = (j_reg == CW'(1)) ? S_SORT_PUT : S_SORT_RDJ;
                end
                else
                    state_next = S_SORT_PUT;
            end
            S_SORT_PUT:
            begin
                score_we    = 1'b1;
                score_waddr = j_reg[AW-1:0];
                score_wdata = v_reg;
                i_next      = i_reg + CW'(1);
                state_next  = (i_reg + CW'(1) == cnt_reg) ? S_LNN : S_SORT_RDV;
            end
            S_LNN:
            begin
                ln_start   = 1'b1;
                ln_k       = cnt_reg;
                state_next = S_LNN_W;
            end
            S_LNN_W:
            begin
                if (ln_done)
                begin
                    lnn_next  = ln_result;
                    i_next    = cnt_reg;
                    best_next = 32'sh8000_0000;
                    if (cnt_reg == '0)
                    begin
                        ready_next = 1'b1;
                        state_next = S_SR_INIT;
                    end
                    else
                        state_next = S_BK_LN;
                end
            end
            S_BK_LN:
            begin
                ln_start    = 1'b1;
                ln_k        = i_reg;
                score_raddr = AW'(i_reg - CW'(1));
                state_next  = S_BK_W;
            end
            S_BK_W:
            begin
                score_raddr = AW'(i_reg - CW'(1));
                if (ln_done)
                begin
                    sum_next = $signed(SW'(score_rdata)) + $signed(SW'(pi0_reg))
                             + $signed(SW'(ln_result)) - $signed(SW'(lnn_reg));
                    state_next = S_BK_WR;
                end
            end
            S_BK_WR:
            begin
                // Store the backward running maximum
                q_we      = 1'b1;
                q_waddr   = AW'(i_reg - CW'(1));
                q_wdata   = new_q;
                best_next = new_q;
                i_next    = i_reg - CW'(1);
                if (i_reg == CW'(1))
                begin
                    ready_next = 1'b1;
                    state_next = S_SR_INIT;
                end
                else
                    state_next = S_BK_LN;
            end
            S_SR_INIT:
            begin
                lo_next    = '0;
                hi_next    = cnt_reg;
                eq_next    = 1'b0;
                state_next = S_SR_CHK;
            end
            S_SR_CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next    = mid_sum[AW-1:0];
                    score_raddr = mid_sum[AW-1:0];
                    state_next  = S_SR_CMP;
                end
                else
                    state_next = S_SR_END;
            end
            S_SR_CMP:
            begin
                // Narrow to the first entry not above the key
                if (score_rdata <= key_reg)
                begin
                    hi_next = CW'(mid_reg);
                    eq_next = (score_rdata == key_reg);
                end
                else
                    lo_next = CW'(mid_reg) + CW'(1);
                state_next = S_SR_CHK;
            end
            S_SR_END:
            begin
                if (eq_reg)
                    state_next = S_SR_Q;
                else
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = bhq_pkg::ST_NOTFOUND;
                    state_next      = S_IDLE;
                end
            end
            S_SR_Q:
            begin
                out_valid_next  = 1'b1;
                out_data_next   = q_rdata;
                out_status_next = bhq_pkg::ST_OK;
                state_next      = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            pi0_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                pi0_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        v_reg          <= v_next;
        lnn_reg        <= lnn_next;
        best_reg       <= best_next;
        sum_reg        <= sum_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        eq_reg         <= eq_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    // Score store
    always_ff @(posedge clk)
    begin
        if (score_we)
            score_mem[score_waddr] <= score_wdata;
        score_rdata <= score_mem[score_raddr];
    end

    // Q store
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        q_rdata <= q_mem[hi_reg[AW-1:0]];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/bhq_ln_unit.sv =====
// Natural log in fixed point on one shared 32x32 multiplier.
// Depends on bhq_pkg.
module bhq_ln_unit #(
    parameter int KW        = 11,
    parameter int FRAC_BITS = bhq_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [KW-1:0]            k,
    output logic                     done,
    output logic [bhq_pkg::LN_W-1:0] result
);
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_SQ   = 2'd1;
    localparam logic [1:0] L_M1   = 2'd2;
    localparam logic [1:0] L_M2   = 2'd3;
    localparam logic [bhq_pkg::ACC_W-1:0] HALF = bhq_pkg::ACC_W'(1) << (31 - FRAC_BITS);

    logic [1:0]                  st_reg, st_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [31:0]                 x_reg, x_next;
    logic [31:0]                 frac_reg, frac_next;
    logic [bhq_pkg::IP_W-1:0]    ip_reg, ip_next;
    logic [bhq_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                        done_reg, done_next;
    logic [bhq_pkg::IP_W-1:0]    ip_c;
    logic [31:0]                 mul_a, mul_b;
    logic [63:0]                 prod;
    logic [33:0]                 sq;
    logic [bhq_pkg::ACC_W-1:0]   rnd;

    // Find floor(log2 k)
    always_comb
    begin
        ip_c = '0;
        for (int b = 0; b < KW; b++)
        begin
            if (k[b])
                ip_c = bhq_pkg::IP_W'(b);
        end
    end

    // Shared multiplier
    always_comb
    begin
        unique case (st_reg)
            L_SQ:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            L_M1:
            begin
                mul_a = frac_reg;
                mul_b = bhq_pkg::LN2_Q32;
            end
            L_M2:
            begin
                mul_a = 32'(ip_reg);
                mul_b = bhq_pkg::LN2_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);
    assign sq   = prod[63:30];

    // Sequence: normalize, 32 squarings, two ln2 products
    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        frac_next = frac_reg;
        ip_next   = ip_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        unique case (st_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    ip_next   = ip_c;
                    x_next    = 32'((64'(k) << 30) >> ip_c);
                    frac_next = '0;
                    cnt_next  = '0;
                    st_next   = L_SQ;
                end
            end
            L_SQ:
            begin
                if (sq >= 34'(64'h8000_0000))
                begin
                    x_next    = 32'(sq >> 1);
                    frac_next = {frac_reg[30:0], 1'b1};
                end
                else
                begin
                    x_next    = sq[31:0];
                    frac_next = {frac_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    st_next = L_M1;
            end
            L_M1:
            begin
                acc_next = bhq_pkg::ACC_W'(prod[63:32]);
                st_next  = L_M2;
            end
            L_M2:
            begin
                acc_next  = acc_reg + bhq_pkg::ACC_W'(prod);
                done_next = 1'b1;
                st_next   = L_IDLE;
            end
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= L_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        ip_reg   <= ip_next;
        acc_reg  <= acc_next;
    end

    // Round to nearest at the output scale
    assign rnd    = (acc_reg + HALF) >> (32 - FRAC_BITS);
    assign result = rnd[bhq_pkg::LN_W-1:0];
    assign done   = done_reg;

endmodule

// ===== rtl/bhq_checker.sv =====
// Port-level checker for the q-value block, bound to the top level.
// Depends on bhq_pkg and benjamini_hochberg_qvalue_defines.svh.
`include "benjamini_hochberg_qvalue_defines.svh"

module bhq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    // Hold a result that is not taken
    `BHQ_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
    // Take a request only with room for its result
    `BHQ_ASSERT_IMP(a_room, clk, rst_n, s_tready, !m_tvalid || m_tready, "no room for result")
    // Answer non-query requests in the next cycle
    `BHQ_ASSERT_NXT(a_fast, clk, rst_n,
        s_tvalid && s_tready && s_tuser[1:0] != bhq_pkg::OP_QUERY, m_tvalid, "slow reply")
    // Zero the value unless the query succeeded
    `BHQ_ASSERT_IMP(a_zero, clk, rst_n, m_tvalid && m_tuser != bhq_pkg::ST_OK,
        m_tdata == 32'd0, "stray value")

endmodule

bind benjamini_hochberg_qvalue bhq_checker u_bhq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// Testbench for benjamini_hochberg_qvalue: stream driver, result monitor and q-value predictor.
// Depends on bhq_pkg and the benjamini_hochberg_qvalue RTL; needs nothing else.
module tb;

    localparam int          DEPTH      = 1024;
    localparam int          FRAC       = 16;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          STALL_LIMIT = 300000;
    localparam int          LONG_HOLD  = 400;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] score;
        logic        unscored;
    } request_t;

    typedef struct packed {
        logic [31:0] neg_log_q;
        logic [2:0]  status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    benjamini_hochberg_qvalue dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state
    logic [31:0]    pi0_m;
    logic [31:0]    score_m [DEPTH];
    int             qv_m [DEPTH];
    int             count_m;
    bit             ready_m;

    request_t       pending_reqs [$];
    answer_t        expected_answers [$];
    int             errors;
    int             n_requests;
    int             n_answers;
    int             n_ok;
    int             n_full;
    int             n_notfound;
    int             n_rebuilds;
    bit             idle_free;
    bit             pressure_on;
    bit             hold_done;
    int             hold_cnt;
    int             stall_cnt;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Natural log in fixed point via log2 by repeated squaring
    function automatic longint unsigned ln_q(input logic [31:0] k);
        longint unsigned x;
        longint unsigned frac;
        longint unsigned r;
        int ip;
        ip = 0;
        frac = 0;
        if (k == 0)
            return 0;
        while (ip < 31 && (k >> (ip + 1)) != 0)
            ip++;
        x = ({32'd0, k} << 30) >> ip;
        for (int b = 0; b < 32; b++)
        begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30))
            begin
                x = x >> 1;
                frac = frac | 1;
            end
        end
        r = longint'(ip) * 64'd2977044472 + ((frac * 64'd2977044472) >> 32);
        return (r + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
    endfunction

    // Sort descending, compute fdr per rank, then backward running max
    task automatic rebuild_tables();
        int n;
        int j;
        logic [31:0] v;
        longint lnn;
        longint sum;
        int best;
        n = count_m;
        for (int i = 1; i < n; i++)
        begin
            v = score_m[i];
            j = i;
            while (j > 0 && score_m[j - 1] < v)
            begin
                score_m[j] = score_m[j - 1];
                j--;
            end
            score_m[j] = v;
        end
        lnn = longint'(ln_q(n));
        for (int i = 0; i < n; i++)
        begin
            sum = longint'({32'd0, score_m[i]}) + longint'({32'd0, pi0_m})
                + longint'(ln_q(i + 1)) - lnn;
            if (sum > 64'sd2147483647)
                qv_m[i] = 32'h7fffffff;
            else if (sum < -64'sd2147483648)
                qv_m[i] = 32'h80000000;
            else
                qv_m[i] = int'(sum);
        end
        best = 32'h80000000;
        for (int i = n; i > 0; i--)
        begin
            if (qv_m[i - 1] > best)
                best = qv_m[i - 1];
            else
                qv_m[i - 1] = best;
        end
        ready_m = 1'b1;
        n_rebuilds++;
    endtask

    // Advance the predictor by one request and return its answer
    task automatic predict_answer(input request_t r, output answer_t a);
        a.neg_log_q = '0;
        a.status = bhq_pkg::ST_ACCEPTED;
        case (r.op)
            bhq_pkg::OP_LOAD:
            begin
                if (r.unscored)
                    a.status = bhq_pkg::ST_UNSCORED;
                else if (count_m >= DEPTH)
                    a.status = bhq_pkg::ST_FULL;
                else
                begin
                    score_m[count_m] = r.score;
                    count_m++;
                    ready_m = 1'b0;
                end
            end
            bhq_pkg::OP_QUERY:
            begin
                if (r.unscored)
                    a.status = bhq_pkg::ST_NAN;
                else
                begin
                    if (!ready_m)
                        rebuild_tables();
                    a.status = bhq_pkg::ST_NOTFOUND;
                    for (int i = 0; i < count_m; i++)
                    begin
                        if (score_m[i] == r.score)
                        begin
                            a.neg_log_q = qv_m[i];
                            a.status = bhq_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            bhq_pkg::OP_CLEAR:
            begin
                count_m = 0;
                ready_m = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (idle_free || roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // Driver: offer pending requests, predict on each accepted one
    int       src_gap;
    request_t cur_req;
    answer_t  pred;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_answer(cur_req, pred);
                expected_answers.push_back(pred);
                n_requests++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_req.score;
                    s_tuser  <= {cur_req.unscored, cur_req.op};
                    src_gap  <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, one long hold, compare against oldest expectation
    int      sink_gap;
    answer_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_gap  <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_answers++;
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected answer: neg_log_q=%h status=%0d", m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== want.neg_log_q)
                    begin
                        $error("neg_log_q: expected %h actual %h", want.neg_log_q, m_tdata);
                        errors++;
                    end
                    if (want.status == bhq_pkg::ST_OK)
                        n_ok++;
                    if (want.status == bhq_pkg::ST_FULL)
                        n_full++;
                    if (want.status == bhq_pkg::ST_NOTFOUND)
                        n_notfound++;
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else if (pressure_on && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= LONG_HOLD;
                m_tready  <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid)
                    sink_gap <= pick_gap();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("timeout: %0d requests pending, %0d answers awaited",
                     pending_reqs.size(), expected_answers.size());
            $display("tb: errors");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] op, input logic [31:0] s, input logic u);
        request_t r;
        r.op = op;
        r.score = s;
        r.unscored = u;
        pending_reqs.push_back(r);
    endtask

    // Wait until every request is in and every answer is out, sampled between edges
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || expected_answers.size() != 0 || s_tvalid)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the pi0 register while idle
    task automatic write_pi0(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        pi0_m = v;
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // One random data set: often a clear, then loads, then queries with now and then an unused op or an extra load
    int gen_stored;
    task automatic random_set(inout int issued);
        logic [31:0] pool [$];
        logic [31:0] v;
        int k;
        int nq;
        int roll;
        if (gen_stored > 40 || $urandom_range(3) != 0)
        begin
            push_req(bhq_pkg::OP_CLEAR, $urandom, 1'($urandom_range(1)));
            gen_stored = 0;
            issued++;
        end
        k = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(16, 1);
        for (int i = 0; i < k; i++)
        begin
            if (pool.size() > 0 && $urandom_range(3) == 0)
                v = pool[$urandom_range(pool.size() - 1)];
            else
                v = $urandom;
            if ($urandom_range(9) == 0)
                push_req(bhq_pkg::OP_LOAD, v, 1'b1);
            else
            begin
                push_req(bhq_pkg::OP_LOAD, v, 1'b0);
                pool.push_back(v);
                gen_stored++;
            end
            issued++;
        end
        nq = $urandom_range(12, 4);
        for (int i = 0; i < nq; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 72 && pool.size() > 0)
                push_req(bhq_pkg::OP_QUERY, pool[$urandom_range(pool.size() - 1)], 1'b0);
            else if (roll < 82)
                push_req(bhq_pkg::OP_QUERY, $urandom, 1'b0);
            else if (roll < 90)
                push_req(bhq_pkg::OP_QUERY, $urandom, 1'b1);
            else if (roll < 95)
                push_req(OP_UNUSED, $urandom, 1'($urandom_range(1)));
            else
            begin
                v = $urandom;
                push_req(bhq_pkg::OP_LOAD, v, 1'b0);
                pool.push_back(v);
                gen_stored++;
            end
            issued++;
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int issued;
        int nsets;
        errors = 0;
        n_requests = 0;
        n_answers = 0;
        n_ok = 0;
        n_full = 0;
        n_notfound = 0;
        n_rebuilds = 0;
        count_m = 0;
        ready_m = 1'b0;
        pi0_m = '0;
        idle_free = 1'b0;
        pressure_on = 1'b0;
        gen_stored = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, extremes, unscored items, unused op, clear
        push_req(bhq_pkg::OP_QUERY, 32'h0000_0000, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h0001_0000, 1'b1);
        push_req(bhq_pkg::OP_LOAD, 32'h0000_0000, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'hffff_ffff, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h0003_8000, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h0003_8000, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'hffff_ffff, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0000_0000, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0003_8000, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0003_8001, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0003_8000, 1'b1);
        push_req(OP_UNUSED, 32'h5555_aaaa, 1'b1);
        push_req(OP_UNUSED, 32'haaaa_5555, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h7fff_ffff, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h7fff_ffff, 1'b0);
        push_req(bhq_pkg::OP_CLEAR, 32'hffff_ffff, 1'b1);
        push_req(bhq_pkg::OP_QUERY, 32'h0000_0000, 1'b0);
        drain();

        // Largest pi0: results saturate high; pi0 change lands only on rebuild
        write_pi0(32'hffff_ffff);
        push_req(bhq_pkg::OP_LOAD, 32'hffff_ffff, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h0000_0001, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0000_0001, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'hffff_ffff, 1'b0);
        drain();
        write_pi0(32'h0000_0000);
        push_req(bhq_pkg::OP_QUERY, 32'h0000_0001, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h0000_0002, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0000_0001, 1'b0);
        drain();

        // Fill the store with equal scores, overflow it, then query a stored and a dropped score
        write_pi0(32'h0001_2345);
        push_req(bhq_pkg::OP_CLEAR, 32'h0, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            push_req(bhq_pkg::OP_LOAD, 32'h0004_0000, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h1234_5678, 1'b0);
        push_req(bhq_pkg::OP_LOAD, 32'h0004_0000, 1'b1);
        push_req(bhq_pkg::OP_LOAD, 32'hffff_ffff, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h0004_0000, 1'b0);
        push_req(bhq_pkg::OP_QUERY, 32'h1234_5678, 1'b0);
        push_req(bhq_pkg::OP_CLEAR, 32'h0, 1'b0);
        drain();

        // Random sets over several pi0 settings, one phase without idling
        issued = 0;
        nsets = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_pi0(32'h0000_0000);
                1: write_pi0($urandom_range(32'h0004_0000));
                2: write_pi0(32'hffff_ffff);
                default: write_pi0($urandom);
            endcase
            idle_free = (ph == 3);
            pressure_on = (ph == 1);
            for (int s = 0; s < 12 && issued < 700; s++)
            begin
                random_set(issued);
                nsets++;
            end
            drain();
        end

        $display("tb: %0d requests, %0d answers, %0d random sets, %0d table rebuilds",
                 n_requests, n_answers, nsets, n_rebuilds);
        $display("tb: %0d q-values found, %0d misses, %0d overflow drops",
                 n_ok, n_notfound, n_full);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bhq_pkg.sv
rtl/bhq_ln_unit.sv
rtl/benjamini_hochberg_qvalue.sv
rtl/bhq_checker.sv
tb/tb.sv
